>>> sv/stma_pkg.sv
`default_nettype none

package stma_pkg;

	localparam int CAPACITY   = 16;
	localparam int VALUE_BITS = 16;
	localparam int IDX_W      = 16;
	localparam int OUT_VAL_W  = VALUE_BITS + 1;
	localparam int COUNT_W    = 6;
	localparam int STATUS_W   = 2;
	localparam int REQ_W      = 2;
	localparam int CFG_IDX_W  = 2;
	localparam int ADDR_W     = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CNT_W      = $clog2(CAPACITY + 1);

	typedef enum logic [REQ_W-1:0] {
		REQ_LOAD_A = 2'd0,
		REQ_LOAD_B = 2'd1,
		REQ_RUN    = 2'd2
	} req_code_t;

	typedef enum logic [STATUS_W-1:0] {
		STAT_OK       = 2'd0,
		STAT_MISMATCH = 2'd1,
		STAT_OVERFLOW = 2'd2
	} status_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_A_ROWS = 2'd0,
		CFG_A_COLS = 2'd1,
		CFG_B_ROWS = 2'd2,
		CFG_B_COLS = 2'd3
	} cfg_reg_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_MERGE,
		S_SUMMARY
	} merge_state_t;

	typedef struct packed {
		logic [IDX_W-1:0]      row;
		logic [IDX_W-1:0]      col;
		logic [VALUE_BITS-1:0] value;
	} entry_t;

	typedef struct packed {
		logic              en;
		logic [ADDR_W-1:0] addr;
		entry_t            entry;
	} store_wr_t;

endpackage

`default_nettype wire

>>> sv/stma_if.sv
`default_nettype none

interface stma_req_if;
	logic                           valid;
	logic                           ready;
	logic [stma_pkg::REQ_W-1:0]      req_type;
	logic [stma_pkg::IDX_W-1:0]      row;
	logic [stma_pkg::IDX_W-1:0]      col;
	logic [stma_pkg::VALUE_BITS-1:0] value;

	modport source (output valid, output req_type, output row, output col, output value,
		input ready);
	modport sink (input valid, input req_type, input row, input col, input value,
		output ready);
endinterface

interface stma_rsp_if;
	logic                          valid;
	logic                          ready;
	logic [stma_pkg::IDX_W-1:0]     out_row;
	logic [stma_pkg::IDX_W-1:0]     out_col;
	logic [stma_pkg::OUT_VAL_W-1:0] out_value;
	logic [stma_pkg::COUNT_W-1:0]   out_count;
	logic [stma_pkg::STATUS_W-1:0]  status;
	logic                          is_summary;
	logic                          last;

	modport source (output valid, output out_row, output out_col, output out_value,
		output out_count, output status, output is_summary, output last, input ready);
	modport sink (input valid, input out_row, input out_col, input out_value,
		input out_count, input status, input is_summary, input last, output ready);
endinterface

interface stma_cfg_if;
	logic                           valid;
	logic                           ready;
	logic [stma_pkg::CFG_IDX_W-1:0] index;
	logic [stma_pkg::IDX_W-1:0]     data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

>>> sv/stma_store.sv
`default_nettype none

module stma_store (
	input  wire                       clk,
	input  wire stma_pkg::store_wr_t  wr,
	input  wire [stma_pkg::ADDR_W-1:0] rd_addr,
	output stma_pkg::entry_t          rd_data
);
	import stma_pkg::*;

	entry_t mem [CAPACITY];
	entry_t rd_data_q;

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr] <= wr.entry;
		end
	end

	always_ff @(posedge clk) begin
		rd_data_q <= mem[rd_addr];
	end

	assign rd_data = rd_data_q;

endmodule

`default_nettype wire

>>> sv/sparse_triplet_matrix_add_unit.sv
// load items: one per cycle while idle, no result
// run item: one merge step per unmatched entry or matched pair (zero sums too), then
//   the end check and the summary; output stalls hold the steps back, and a dimension
//   mismatch goes straight to the summary
// results: each is formed combinationally in its step and registered in the output register
// reset clears loaded counts, overflow flag, config registers and the output valid
`default_nettype none

module sparse_triplet_matrix_add_unit (
	input wire        clk,
	input wire        arst_n,
	stma_req_if.sink   req,
	stma_rsp_if.source rsp,
	stma_cfg_if.sink   cfg
);
	import stma_pkg::*;

	merge_state_t state_q, state_d;

	logic [IDX_W-1:0] a_rows_q, a_cols_q, b_rows_q, b_cols_q;
	logic [CNT_W-1:0] a_cnt_q, b_cnt_q;
	logic             ovf_q;
	logic [CNT_W-1:0] i_q, i_d, j_q, j_d;
	logic [COUNT_W-1:0] k_q, k_d;

	logic               rsp_valid_q;
	logic [IDX_W-1:0]   rsp_row_q, rsp_col_q;
	logic [OUT_VAL_W-1:0] rsp_value_q;
	logic [COUNT_W-1:0] rsp_count_q;
	logic [STATUS_W-1:0] rsp_status_q;
	logic               rsp_sum_q;

	logic               out_load, cnt_clear;
	logic [IDX_W-1:0]   o_row, o_col;
	logic [OUT_VAL_W-1:0] o_value;
	logic [COUNT_W-1:0] o_count;
	logic [STATUS_W-1:0] o_status;
	logic               o_sum;

	logic req_xfer, run_xfer, out_free, a_av, b_av, mism;
	logic [OUT_VAL_W-1:0] a_ext, b_ext, sum;
	logic [2*IDX_W-1:0] a_key, b_key;

	store_wr_t a_wr, b_wr;
	entry_t    a_rd, b_rd, in_entry;

	assign req.ready = (state_q == S_IDLE);
	assign cfg.ready = 1'b1;
	assign req_xfer  = req.valid && req.ready;
	assign run_xfer  = req_xfer && (req.req_type == REQ_RUN);
	assign out_free  = !rsp_valid_q || rsp.ready;
	assign a_av      = i_q < a_cnt_q;
	assign b_av      = j_q < b_cnt_q;
	assign mism      = (a_rows_q != b_rows_q) || (a_cols_q != b_cols_q);
	assign a_ext     = {a_rd.value[VALUE_BITS-1], a_rd.value};
	assign b_ext     = {b_rd.value[VALUE_BITS-1], b_rd.value};
	assign sum       = a_ext + b_ext;
	assign a_key     = {a_rd.row, a_rd.col};
	assign b_key     = {b_rd.row, b_rd.col};

	assign in_entry = '{row: req.row, col: req.col, value: req.value};

	always_comb begin
		a_wr.en    = req_xfer && (req.req_type == REQ_LOAD_A) && (a_cnt_q < CNT_W'(CAPACITY));
		a_wr.addr  = a_cnt_q[ADDR_W-1:0];
		a_wr.entry = in_entry;
		b_wr.en    = req_xfer && (req.req_type == REQ_LOAD_B) && (b_cnt_q < CNT_W'(CAPACITY));
		b_wr.addr  = b_cnt_q[ADDR_W-1:0];
		b_wr.entry = in_entry;
	end

	stma_store u_store_a (
		.clk     (clk),
		.wr      (a_wr),
		.rd_addr (i_d[ADDR_W-1:0]),
		.rd_data (a_rd)
	);

	stma_store u_store_b (
		.clk     (clk),
		.wr      (b_wr),
		.rd_addr (j_d[ADDR_W-1:0]),
		.rd_data (b_rd)
	);

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (run_xfer) begin
					state_d = mism ? S_SUMMARY : S_MERGE;
				end
			end
			S_MERGE: begin
				if (!a_av && !b_av) begin
					state_d = S_SUMMARY;
				end
			end
			S_SUMMARY: begin
				if (out_free) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		i_d       = i_q;
		j_d       = j_q;
		k_d       = k_q;
		out_load  = 1'b0;
		cnt_clear = 1'b0;
		o_row     = a_rd.row;
		o_col     = a_rd.col;
		o_value   = a_ext;
		o_count   = '0;
		o_status  = STAT_OK;
		o_sum     = 1'b0;
		case (state_q)
			S_IDLE: begin
				i_d = '0;
				j_d = '0;
				k_d = '0;
			end
			S_MERGE: begin
				if (out_free && (a_av || b_av)) begin
					if (a_av && (!b_av || (a_key < b_key))) begin
						out_load = 1'b1;
						i_d      = i_q + 1'b1;
					end else if (!a_av || (a_key > b_key)) begin
						out_load = 1'b1;
						o_row    = b_rd.row;
						o_col    = b_rd.col;
						o_value  = b_ext;
						j_d      = j_q + 1'b1;
					end else begin
						out_load = (sum != '0);
						o_value  = sum;
						i_d      = i_q + 1'b1;
						j_d      = j_q + 1'b1;
					end
					k_d = k_q + COUNT_W'(out_load);
				end
			end
			S_SUMMARY: begin
				o_value = '0;
				o_sum   = 1'b1;
				if (mism) begin
					o_row    = '0;
					o_col    = '0;
					o_count  = '0;
					o_status = STAT_MISMATCH;
				end else begin
					o_row    = a_rows_q;
					o_col    = a_cols_q;
					o_count  = k_q;
					o_status = ovf_q ? STAT_OVERFLOW : STAT_OK;
				end
				if (out_free) begin
					out_load  = 1'b1;
					cnt_clear = 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			i_q     <= '0;
			j_q     <= '0;
			k_q     <= '0;
		end else begin
			state_q <= state_d;
			i_q     <= i_d;
			j_q     <= j_d;
			k_q     <= k_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			a_cnt_q <= '0;
			b_cnt_q <= '0;
			ovf_q   <= 1'b0;
		end else if (cnt_clear) begin
			a_cnt_q <= '0;
			b_cnt_q <= '0;
			ovf_q   <= 1'b0;
		end else if (req_xfer) begin
			case (req.req_type)
				REQ_LOAD_A: begin
					if (a_wr.en) begin
						a_cnt_q <= a_cnt_q + 1'b1;
					end else begin
						ovf_q <= 1'b1;
					end
				end
				REQ_LOAD_B: begin
					if (b_wr.en) begin
						b_cnt_q <= b_cnt_q + 1'b1;
					end else begin
						ovf_q <= 1'b1;
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			a_rows_q <= '0;
			a_cols_q <= '0;
			b_rows_q <= '0;
			b_cols_q <= '0;
		end else if (cfg.valid && cfg.ready) begin
			case (cfg.index)
				CFG_A_ROWS: a_rows_q <= cfg.data;
				CFG_A_COLS: a_cols_q <= cfg.data;
				CFG_B_ROWS: b_rows_q <= cfg.data;
				CFG_B_COLS: b_cols_q <= cfg.data;
				default: begin
				end
			endcase
		end
	end

	// output register parts the merge walk from the sink
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (out_load) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			rsp_row_q    <= o_row;
			rsp_col_q    <= o_col;
			rsp_value_q  <= o_value;
			rsp_count_q  <= o_count;
			rsp_status_q <= o_status;
			rsp_sum_q    <= o_sum;
		end
	end

	assign rsp.valid      = rsp_valid_q;
	assign rsp.out_row    = rsp_row_q;
	assign rsp.out_col    = rsp_col_q;
	assign rsp.out_value  = rsp_value_q;
	assign rsp.out_count  = rsp_count_q;
	assign rsp.status     = rsp_status_q;
	assign rsp.is_summary = rsp_sum_q;
	assign rsp.last       = rsp_sum_q;

endmodule

`default_nettype wire
